// ----- rtl/core/rpma_pkg.sv -----
// ----------------------------------------------------------------------------
// rpma_pkg
// Shared constants, controller states and command/status types for the
// roll/pitch moving average block.
// ----------------------------------------------------------------------------
package rpma_pkg;

  localparam int unsigned MAX_WINDOW_DEF  = 128;
  localparam int unsigned ANGLE_WIDTH_DEF = 16;
  localparam int unsigned CFG_WIDTH       = 8;
  localparam int unsigned WINDOW_RESET    = 100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;     // capture sample, read oldest ring entry
    logic update;     // update sums, write ring, advance slot
    logic div_start;  // load dividers from the sums
    logic div_step;   // one quotient bit
    logic out_load;   // move quotients into the output register
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ----- rtl/core/rpma_if.sv -----
// ----------------------------------------------------------------------------
// rpma_if
// Valid/ready channels for attitude samples and averaged results.
// ----------------------------------------------------------------------------
interface rpma_in_if #(
  parameter int unsigned ANGLE_WIDTH = rpma_pkg::ANGLE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] roll_in;
  logic signed [ANGLE_WIDTH-1:0] pitch_in;
  logic signed [ANGLE_WIDTH-1:0] yaw_in;

  modport source (output valid, output roll_in, output pitch_in, output yaw_in,
                  input ready);
  modport sink   (input valid, input roll_in, input pitch_in, input yaw_in,
                  output ready);
endinterface

interface rpma_out_if #(
  parameter int unsigned ANGLE_WIDTH = rpma_pkg::ANGLE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] roll_avg;
  logic signed [ANGLE_WIDTH-1:0] pitch_avg;
  logic signed [ANGLE_WIDTH-1:0] yaw_out;

  modport source (output valid, output roll_avg, output pitch_avg, output yaw_out,
                  input ready);
  modport sink   (input valid, input roll_avg, input pitch_avg, input yaw_out,
                  output ready);
endinterface

// ----- rtl/core/rpma_div.sv -----
// ----------------------------------------------------------------------------
// rpma_div
// Serial signed-by-unsigned restoring divider, one quotient bit per step,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module rpma_div #(
  parameter int unsigned DW = 23,
  parameter int unsigned VW = 8
) (
  input  logic                 clk_i,
  input  logic                 start_i,
  input  logic                 step_i,
  input  logic signed [DW-1:0] dividend_i,
  input  logic        [VW-1:0] divisor_i,
  output logic signed [DW-1:0] quotient_o
);

  logic          neg_q;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW:0]   shifted;
  logic [VW:0]   trial;

  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    trial   = shifted - {1'b0, divisor_i};
    if (shifted >= {1'b0, divisor_i}) begin
      rem_d = trial[VW-1:0];
      quo_d = {quo_q[DW-2:0], 1'b1};
    end else begin
      rem_d = shifted[VW-1:0];
      quo_d = {quo_q[DW-2:0], 1'b0};
    end
  end

  // datapath registers, sequenced by the controller
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DW-1];
      quo_q <= dividend_i[DW-1] ? DW'(-dividend_i) : DW'(dividend_i);
      rem_q <= '0;
    end else if (step_i) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// ----- rtl/core/rpma_ctrl.sv -----
// ----------------------------------------------------------------------------
// rpma_ctrl
// Sequencer: accept, sum update, divider load, serial divide, result load.
// ----------------------------------------------------------------------------
module rpma_ctrl #(
  parameter int unsigned SUM_W = 23
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rpma_pkg::status_t status_i,
  output rpma_pkg::cmd_t    cmd_o
);

  localparam int unsigned CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SUM_W - 1);

  rpma_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpma_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rpma_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = rpma_pkg::ST_UPDATE;
        end
      end
      rpma_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = rpma_pkg::ST_START;
      end
      rpma_pkg::ST_START: begin
        cmd_o.div_start = 1'b1;
        cnt_d           = '0;
        state_d         = rpma_pkg::ST_DIV;
      end
      rpma_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == LAST_STEP) begin
          state_d = rpma_pkg::ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      rpma_pkg::ST_DONE: begin
        // hold until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = rpma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rpma_pkg::ST_IDLE;
      end
    endcase
  end

  a_accept_to_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == rpma_pkg::ST_UPDATE)
    else $error("accept not followed by sum update");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rpma_pkg::ST_DIV |-> cnt_q <= LAST_STEP)
    else $error("divide step counter overrun");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.out_free)
    else $error("result loaded over an untaken result");

endmodule

// ----- rtl/core/rpma_dp.sv -----
// ----------------------------------------------------------------------------
// rpma_dp
// Datapath: window register, sample ring, running sums, two serial
// dividers and the output register.
// ----------------------------------------------------------------------------
module rpma_dp #(
  parameter int unsigned MAX_WINDOW  = rpma_pkg::MAX_WINDOW_DEF,
  parameter int unsigned ANGLE_WIDTH = rpma_pkg::ANGLE_WIDTH_DEF,
  parameter int unsigned SUM_W       = ANGLE_WIDTH + $clog2(MAX_WINDOW)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rpma_pkg::CFG_WIDTH-1:0]   cfg_wdata_i,
  input  rpma_pkg::cmd_t                   cmd_i,
  output rpma_pkg::status_t                status_o,
  input  logic signed [ANGLE_WIDTH-1:0]    roll_i,
  input  logic signed [ANGLE_WIDTH-1:0]    pitch_i,
  input  logic signed [ANGLE_WIDTH-1:0]    yaw_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [ANGLE_WIDTH-1:0]    roll_avg_o,
  output logic signed [ANGLE_WIDTH-1:0]    pitch_avg_o,
  output logic signed [ANGLE_WIDTH-1:0]    yaw_out_o
);

  localparam int unsigned CFG_W  = rpma_pkg::CFG_WIDTH;
  localparam int unsigned IDX_W  = $clog2(MAX_WINDOW);
  localparam int unsigned WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CMP_W  = CFG_W + WIN_W;
  localparam int unsigned EXT_W  = SUM_W - ANGLE_WIDTH;
  localparam int unsigned WIN_RST_I = (rpma_pkg::WINDOW_RESET > MAX_WINDOW) ?
                                      MAX_WINDOW : rpma_pkg::WINDOW_RESET;
  localparam logic [WIN_W-1:0] WIN_RST = WIN_W'(WIN_RST_I);
  localparam logic [CMP_W-1:0] WIN_MAX = CMP_W'(MAX_WINDOW);

  logic [2*ANGLE_WIDTH-1:0] ring_mem [MAX_WINDOW];
  logic [2*ANGLE_WIDTH-1:0] rd_q;

  logic [WIN_W-1:0]        win_q, win_d;
  logic [IDX_W-1:0]        slot_q, slot_d;
  logic [WIN_W-1:0]        fill_q, fill_d;
  logic signed [SUM_W-1:0] roll_sum_q, roll_sum_d;
  logic signed [SUM_W-1:0] pitch_sum_q, pitch_sum_d;

  logic signed [ANGLE_WIDTH-1:0] roll_q, pitch_q, yaw_q;
  logic                          out_valid_q;
  logic signed [ANGLE_WIDTH-1:0] roll_avg_q, pitch_avg_q, yaw_out_q;

  logic [CMP_W-1:0]        cfg_ext;
  logic                    full;
  logic [WIN_W-1:0]        slot_inc;
  logic signed [SUM_W-1:0] roll_new, pitch_new, roll_old, pitch_old;
  logic signed [SUM_W-1:0] roll_quo, pitch_quo;

  // ring storage, no reset; fill count guards reads of stale entries
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      ring_mem[slot_q] <= {roll_q, pitch_q};
    end
    if (cmd_i.accept) begin
      rd_q <= ring_mem[slot_q];
    end
  end

  always_comb begin
    cfg_ext   = CMP_W'(cfg_wdata_i);
    full      = (fill_q >= win_q);
    slot_inc  = WIN_W'(slot_q) + 1'b1;
    roll_new  = {{EXT_W{roll_q[ANGLE_WIDTH-1]}}, roll_q};
    pitch_new = {{EXT_W{pitch_q[ANGLE_WIDTH-1]}}, pitch_q};
    roll_old  = {{EXT_W{rd_q[2*ANGLE_WIDTH-1]}}, rd_q[2*ANGLE_WIDTH-1:ANGLE_WIDTH]};
    pitch_old = {{EXT_W{rd_q[ANGLE_WIDTH-1]}}, rd_q[ANGLE_WIDTH-1:0]};

    win_d       = win_q;
    slot_d      = slot_q;
    fill_d      = fill_q;
    roll_sum_d  = roll_sum_q;
    pitch_sum_d = pitch_sum_q;

    if (cfg_we_i) begin
      if (cfg_ext == '0) begin
        win_d = WIN_W'(1);
      end else if (cfg_ext > WIN_MAX) begin
        win_d = WIN_MAX[WIN_W-1:0];
      end else begin
        win_d = cfg_ext[WIN_W-1:0];
      end
      slot_d      = '0;
      fill_d      = '0;
      roll_sum_d  = '0;
      pitch_sum_d = '0;
    end else if (cmd_i.update) begin
      if (full) begin
        roll_sum_d  = roll_sum_q - roll_old + roll_new;
        pitch_sum_d = pitch_sum_q - pitch_old + pitch_new;
      end else begin
        roll_sum_d  = roll_sum_q + roll_new;
        pitch_sum_d = pitch_sum_q + pitch_new;
        fill_d      = fill_q + 1'b1;
      end
      slot_d = (slot_inc >= win_q) ? '0 : slot_inc[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= WIN_RST;
      slot_q      <= '0;
      fill_q      <= '0;
      roll_sum_q  <= '0;
      pitch_sum_q <= '0;
    end else begin
      win_q       <= win_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      roll_sum_q  <= roll_sum_d;
      pitch_sum_q <= pitch_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      roll_q  <= roll_i;
      pitch_q <= pitch_i;
      yaw_q   <= yaw_i;
    end
  end

  rpma_div #(.DW(SUM_W), .VW(WIN_W)) u_div_roll (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (roll_sum_q),
    .divisor_i  (win_q),
    .quotient_o (roll_quo)
  );

  rpma_div #(.DW(SUM_W), .VW(WIN_W)) u_div_pitch (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (pitch_sum_q),
    .divisor_i  (win_q),
    .quotient_o (pitch_quo)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      roll_avg_q  <= roll_quo[ANGLE_WIDTH-1:0];
      pitch_avg_q <= pitch_quo[ANGLE_WIDTH-1:0];
      yaw_out_q   <= yaw_q;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign roll_avg_o        = roll_avg_q;
  assign pitch_avg_o       = pitch_avg_q;
  assign yaw_out_o         = yaw_out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= win_q)
    else $error("fill count beyond window length");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WIN_W'(slot_q) < win_q)
    else $error("write slot outside window");

endmodule

// ----- rtl/core/roll_pitch_moving_average.sv -----
// ----------------------------------------------------------------------------
// roll_pitch_moving_average
// Boxcar moving average of roll and pitch over a configurable window,
// yaw passed through.
// ----------------------------------------------------------------------------
//  channel   dir  transaction
//  in_i      in   roll_in, pitch_in, yaw_in (valid/ready)
//  out_o     out  roll_avg, pitch_avg, yaw_out (valid/ready)
//  cfg       in   cfg_we_i / cfg_wdata_i: window_length, clears fill count and sums
//
//  one sample at a time: a new sample is taken only after the previous
//  result is loaded; the serial dividers give one quotient bit per cycle
//  the result sits in an output register; a stalled sink holds the block
//  only at the result load, after the divide
//  reset clears window state and sums at once; the ring is not cleared
// ----------------------------------------------------------------------------
module roll_pitch_moving_average #(
  parameter int unsigned MAX_WINDOW  = rpma_pkg::MAX_WINDOW_DEF,
  parameter int unsigned ANGLE_WIDTH = rpma_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rpma_in_if.sink                        in_i,
  rpma_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [rpma_pkg::CFG_WIDTH-1:0] cfg_wdata_i
);

  localparam int unsigned SUM_W = ANGLE_WIDTH + $clog2(MAX_WINDOW);

  rpma_pkg::cmd_t    cmd;
  rpma_pkg::status_t status;

  rpma_ctrl #(.SUM_W(SUM_W)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rpma_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .SUM_W       (SUM_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .roll_i      (in_i.roll_in),
    .pitch_i     (in_i.pitch_in),
    .yaw_i       (in_i.yaw_in),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .roll_avg_o  (out_o.roll_avg),
    .pitch_avg_o (out_o.pitch_avg),
    .yaw_out_o   (out_o.yaw_out)
  );

endmodule
